// ===== hdl/smeu_pkg.sv =====
// Shared types and constants for the stack machine execute unit.
`timescale 1ns / 1ps
`default_nettype none
package smeu_pkg;

   localparam int DATA_W = 64;
   localparam int PC_W   = 16;
   localparam int OP_W   = 5;
   localparam int IMM_W  = 16;
   localparam int NEED_W = 11;
   localparam int ERR_W  = 3;
   localparam int CHAR_W = 8;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH0    = 5'd0,
      OP_POP      = 5'd1,
      OP_LDCONST  = 5'd2,
      OP_LDTABLE  = 5'd3,
      OP_LDARG    = 5'd4,
      OP_STARG    = 5'd5,
      OP_LDVAR    = 5'd6,
      OP_STVAR    = 5'd7,
      OP_LDARR    = 5'd8,
      OP_STARR    = 5'd9,
      OP_INPUT    = 5'd10,
      OP_PRINT    = 5'd11,
      OP_ADD      = 5'd12,
      OP_SUB      = 5'd13,
      OP_MUL      = 5'd14,
      OP_DIV      = 5'd15,
      OP_MOD      = 5'd16,
      OP_GOTO     = 5'd17,
      OP_GOTO_NZ  = 5'd18,
      OP_GOTO_EQ  = 5'd19,
      OP_GOTO_LT  = 5'd20,
      OP_GOTO_LE  = 5'd21,
      OP_CALL     = 5'd22,
      OP_RET      = 5'd23,
      OP_HALT     = 5'd24
   } opcode_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE     = 3'd0,
      ERR_OVERFLOW = 3'd1,
      ERR_DIV_ZERO = 3'd2,
      ERR_INPUT    = 3'd3,
      ERR_ILLEGAL  = 3'd4
   } error_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD0,
      ST_RD1,
      ST_RD2,
      ST_EXEC,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_DIV,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic clear;
      logic rd0;
      logic rd1;
      logic rd2;
      logic exec;
      logic mul1;
      logic mul2;
      logic mul3;
      logic div_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_mul;
      logic is_div;
      logic div_zero;
      logic div_last;
      logic rsp_free;
   } status_type;

endpackage
`default_nettype wire

// ===== hdl/smeu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module smeu_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== hdl/smeu_ctrl.sv =====
// Sequencing state machine of the stack machine execute unit.
`timescale 1ns / 1ps
`default_nettype none
module smeu_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire smeu_pkg::status_type status,
   output smeu_pkg::cmd_type         cmd
);

   smeu_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smeu_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         smeu_pkg::ST_CLEAR: begin
            if (status.clear_last) state_in = smeu_pkg::ST_IDLE;
         end
         smeu_pkg::ST_IDLE: begin
            if (req_valid) state_in = smeu_pkg::ST_RD0;
         end
         smeu_pkg::ST_RD0: state_in = smeu_pkg::ST_RD1;
         smeu_pkg::ST_RD1: state_in = smeu_pkg::ST_RD2;
         smeu_pkg::ST_RD2: state_in = smeu_pkg::ST_EXEC;
         smeu_pkg::ST_EXEC: begin
            if (status.is_mul) begin
               state_in = smeu_pkg::ST_MUL1;
            end else if (status.is_div && !status.div_zero) begin
               state_in = smeu_pkg::ST_DIV;
            end else begin
               state_in = smeu_pkg::ST_COMMIT;
            end
         end
         smeu_pkg::ST_MUL1: state_in = smeu_pkg::ST_MUL2;
         smeu_pkg::ST_MUL2: state_in = smeu_pkg::ST_MUL3;
         smeu_pkg::ST_MUL3: state_in = smeu_pkg::ST_COMMIT;
         smeu_pkg::ST_DIV: begin
            if (status.div_last) state_in = smeu_pkg::ST_COMMIT;
         end
         smeu_pkg::ST_COMMIT: begin
            if (status.rsp_free) state_in = smeu_pkg::ST_IDLE;
         end
         default: state_in = smeu_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = (state_ff == smeu_pkg::ST_IDLE);
      cmd          = '0;
      cmd.accept   = (state_ff == smeu_pkg::ST_IDLE) && req_valid;
      cmd.clear    = (state_ff == smeu_pkg::ST_CLEAR);
      cmd.rd0      = (state_ff == smeu_pkg::ST_RD0);
      cmd.rd1      = (state_ff == smeu_pkg::ST_RD1);
      cmd.rd2      = (state_ff == smeu_pkg::ST_RD2);
      cmd.exec     = (state_ff == smeu_pkg::ST_EXEC);
      cmd.mul1     = (state_ff == smeu_pkg::ST_MUL1);
      cmd.mul2     = (state_ff == smeu_pkg::ST_MUL2);
      cmd.mul3     = (state_ff == smeu_pkg::ST_MUL3);
      cmd.div_step = (state_ff == smeu_pkg::ST_DIV);
      cmd.commit   = (state_ff == smeu_pkg::ST_COMMIT) && status.rsp_free;
   end

endmodule
`default_nettype wire

// ===== hdl/smeu_datapath.sv =====
// Datapath: machine state, stack and array memories, multiplier, divider, result register.
`timescale 1ns / 1ps
`default_nettype none
module smeu_datapath #(
   parameter int DATA_DEPTH     = 1024,
   parameter int RETURN_DEPTH   = 512,
   parameter int VARIABLE_COUNT = 16,
   parameter int ARRAY_DEPTH    = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire smeu_pkg::cmd_type                   cmd,
   output smeu_pkg::status_type                     status,
   input  wire logic        [smeu_pkg::OP_W-1:0]    req_opcode,
   input  wire logic signed [smeu_pkg::IMM_W-1:0]   req_immediate,
   input  wire logic signed [smeu_pkg::DATA_W-1:0]  req_table_constant,
   input  wire logic        [smeu_pkg::NEED_W-1:0]  req_callee_frame_need,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic             [smeu_pkg::PC_W-1:0]    rsp_next_pc,
   output logic                                     rsp_print_valid,
   output logic             [smeu_pkg::CHAR_W-1:0]  rsp_print_char,
   output logic                                     rsp_halted,
   output logic signed      [smeu_pkg::DATA_W-1:0]  rsp_result_value,
   output logic             [smeu_pkg::ERR_W-1:0]   rsp_error_code
);

   localparam int DW   = smeu_pkg::DATA_W;
   localparam int PW   = smeu_pkg::PC_W;
   localparam int STW  = $clog2(DATA_DEPTH + 1);
   localparam int DAW  = $clog2(DATA_DEPTH);
   localparam int RDEP = RETURN_DEPTH / 2;
   localparam int RAW  = $clog2(RDEP);
   localparam int RPW  = $clog2(RDEP + 1);
   localparam int AAW  = $clog2(ARRAY_DEPTH);
   localparam int VIW  = (VARIABLE_COUNT > 1) ? $clog2(VARIABLE_COUNT) : 1;
   localparam int SAW  = ((STW > smeu_pkg::IMM_W) ? STW : smeu_pkg::IMM_W) + 2;
   localparam int CSW  = ((STW > smeu_pkg::NEED_W) ? STW : smeu_pkg::NEED_W) + 1;
   localparam int PRW  = PW + STW;
   localparam logic [SAW-1:0] DD_S = SAW'(DATA_DEPTH);
   localparam logic [CSW-1:0] DD_C = CSW'(DATA_DEPTH);
   localparam logic [RPW+1:0] RD_C = (RPW + 2)'(RETURN_DEPTH);
   localparam logic [AAW-1:0] CLR_LAST = AAW'(ARRAY_DEPTH - 1);

   // machine state
   logic [PW-1:0]  pc_ff, pc_in;
   logic [STW-1:0] st_ff, st_in;
   logic [STW-1:0] fb_ff, fb_in;
   logic [RPW-1:0] rp_ff, rp_in;
   logic [DW-1:0]  var_ff [VARIABLE_COUNT];

   // current transaction
   logic [smeu_pkg::OP_W-1:0]   op_ff;
   logic [smeu_pkg::IMM_W-1:0]  imm_ff;
   logic [DW-1:0]               tconst_ff;
   logic [smeu_pkg::NEED_W-1:0] need_ff;
   logic [DW-1:0]               d0_ff, d1_ff;

   logic [DW-1:0]  prod_ff, acc_ff;
   logic [DW-1:0]  quo_ff, rem_ff, dvs_ff;
   logic           neg_a_ff, neg_b_ff;
   logic [5:0]     div_cnt_ff;
   logic [AAW-1:0] clr_ff;

   // memory ports
   logic [DW-1:0]  ds_rd, ga_rd;
   logic [PRW-1:0] rs_rd;
   logic           ds_we, ga_we, rs_we, var_we;
   logic [DAW-1:0] ds_wa, ds_ra;
   logic [DW-1:0]  ds_wd;
   logic [AAW-1:0] ga_wa;
   logic [DW-1:0]  ga_wd;

   // decode helpers
   logic [SAW-1:0] imm_s, fb_s, arg_slot, nt_raw;
   logic [STW-1:0] st_m1, st_m2, st_pop, st_pop2, nt;
   logic           st_pos, st_ge2, arg_ok, var_ok, a_ok, rp_pos, call_bad, push_full;
   logic [DAW-1:0] arg_idx, top_idx, sec_idx, nt_idx;
   logic [VIW-1:0] var_idx;
   logic [AAW-1:0] a_idx;
   logic [DW-1:0]  var_rd;
   logic [PW-1:0]  pc_inc, target, ret_pc;
   logic [STW-1:0] ret_fb;
   logic [RPW-1:0] rp_m1;

   // arithmetic
   logic [31:0]    mul_a, mul_b;
   logic [DW:0]    div_shift, div_diff;
   logic [DW-1:0]  div_res, arith_v;

   // commit decisions
   logic                   push, pv;
   logic [DW-1:0]          push_val, rval;
   logic [smeu_pkg::CHAR_W-1:0] pch;
   logic                   hlt;
   smeu_pkg::error_type    err;

   assign imm_s    = {{(SAW - smeu_pkg::IMM_W){imm_ff[smeu_pkg::IMM_W-1]}}, imm_ff};
   assign fb_s     = {{(SAW - STW){1'b0}}, fb_ff};
   assign arg_slot = fb_s - imm_s;
   assign arg_ok   = !arg_slot[SAW-1] && (arg_slot < DD_S);
   assign arg_idx  = arg_slot[DAW-1:0];
   assign nt_raw   = fb_s - imm_s + SAW'(1);

   always_comb begin
      if (nt_raw[SAW-1] || (nt_raw == '0)) begin
         nt = STW'(1);
      end else if (nt_raw > DD_S) begin
         nt = STW'(DATA_DEPTH);
      end else begin
         nt = nt_raw[STW-1:0];
      end
   end

   assign st_m1   = st_ff - STW'(1);
   assign st_m2   = st_ff - STW'(2);
   assign st_pos  = (st_ff != '0);
   assign st_ge2  = (st_ff > STW'(1));
   assign st_pop  = st_pos ? st_m1 : st_ff;
   assign st_pop2 = st_ge2 ? st_m2 : '0;
   assign top_idx = st_m1[DAW-1:0];
   assign sec_idx = st_m2[DAW-1:0];
   assign nt_idx  = DAW'(nt - STW'(1));
   assign push_full = (st_ff >= STW'(DATA_DEPTH));

   assign var_ok  = !imm_ff[smeu_pkg::IMM_W-1] &&
                    (imm_ff < smeu_pkg::IMM_W'(VARIABLE_COUNT));
   assign var_idx = imm_ff[VIW-1:0];
   assign var_rd  = var_ok ? var_ff[var_idx] : '0;

   assign a_ok  = (d0_ff < DW'(ARRAY_DEPTH));
   assign a_idx = d0_ff[AAW-1:0];

   assign rp_pos = (rp_ff != '0);
   assign rp_m1  = rp_ff - RPW'(1);
   assign ret_fb = rp_pos ? rs_rd[STW-1:0] : '0;
   assign ret_pc = rp_pos ? rs_rd[PRW-1:STW] : '0;

   assign call_bad = (({{(CSW - STW){1'b0}}, st_ff} +
                       {{(CSW - smeu_pkg::NEED_W){1'b0}}, need_ff}) >= DD_C) ||
                     (({1'b0, rp_ff, 1'b0} + (RPW + 2)'(2)) >= RD_C);

   assign pc_inc = pc_ff + PW'(1);
   assign target = imm_ff + PW'(1);

   // ---------------- memories ----------------
   assign ds_ra = cmd.rd1 ? sec_idx
                : ((smeu_pkg::opcode_type'(op_ff) == smeu_pkg::OP_LDARG) ? arg_idx : top_idx);

   smeu_ram #(.WIDTH(DW), .DEPTH(DATA_DEPTH)) u_data_stack (
      .clock   (clock),
      .wr_en   (ds_we && cmd.commit),
      .wr_addr (ds_wa),
      .wr_data (ds_wd),
      .rd_en   (cmd.rd0 || cmd.rd1),
      .rd_addr (ds_ra),
      .rd_data (ds_rd)
   );

   // one entry holds a saved counter and frame base
   smeu_ram #(.WIDTH(PRW), .DEPTH(RDEP)) u_return_stack (
      .clock   (clock),
      .wr_en   (rs_we && cmd.commit),
      .wr_addr (rp_ff[RAW-1:0]),
      .wr_data ({pc_ff, fb_ff}),
      .rd_en   (cmd.rd0),
      .rd_addr (rp_m1[RAW-1:0]),
      .rd_data (rs_rd)
   );

   assign ga_wa = cmd.clear ? clr_ff : a_idx;
   assign ga_wd = cmd.clear ? '0 : d1_ff;

   smeu_ram #(.WIDTH(DW), .DEPTH(ARRAY_DEPTH)) u_global_array (
      .clock   (clock),
      .wr_en   (cmd.clear || (ga_we && cmd.commit)),
      .wr_addr (ga_wa),
      .wr_data (ga_wd),
      .rd_en   (cmd.rd2),
      .rd_addr (a_idx),
      .rd_data (ga_rd)
   );

   // ---------------- multiply / divide ----------------
   // low 64 bits of the product from three 32x32 partial products
   assign mul_a = cmd.mul2 ? d1_ff[63:32] : d1_ff[31:0];
   assign mul_b = cmd.mul1 ? d0_ff[63:32] : d0_ff[31:0];

   assign div_shift = {rem_ff, quo_ff[DW-1]};
   assign div_diff  = div_shift - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (cmd.exec || cmd.mul1 || cmd.mul2) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.mul1) begin
         acc_ff <= prod_ff;
      end else if (cmd.mul2 || cmd.mul3) begin
         acc_ff <= acc_ff + {prod_ff[31:0], 32'd0};
      end
      if (cmd.exec) begin
         neg_a_ff   <= d1_ff[DW-1];
         neg_b_ff   <= d0_ff[DW-1];
         quo_ff     <= d1_ff[DW-1] ? (DW'(0) - d1_ff) : d1_ff;
         dvs_ff     <= d0_ff[DW-1] ? (DW'(0) - d0_ff) : d0_ff;
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + 6'd1;
         if (!div_diff[DW]) begin
            rem_ff <= div_diff[DW-1:0];
            quo_ff <= {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_ff <= div_shift[DW-1:0];
            quo_ff <= {quo_ff[DW-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      if (smeu_pkg::opcode_type'(op_ff) == smeu_pkg::OP_MOD) begin
         div_res = neg_a_ff ? (DW'(0) - rem_ff) : rem_ff;
      end else begin
         div_res = (neg_a_ff ^ neg_b_ff) ? (DW'(0) - quo_ff) : quo_ff;
      end
   end

   always_comb begin
      case (smeu_pkg::opcode_type'(op_ff))
         smeu_pkg::OP_ADD: arith_v = d1_ff + d0_ff;
         smeu_pkg::OP_SUB: arith_v = d1_ff - d0_ff;
         smeu_pkg::OP_MUL: arith_v = acc_ff;
         default:          arith_v = (d0_ff == '0) ? '0 : div_res;
      endcase
   end

   // ---------------- commit decode ----------------
   always_comb begin
      st_in    = st_ff;
      fb_in    = fb_ff;
      rp_in    = rp_ff;
      pc_in    = pc_inc;
      pv       = 1'b0;
      pch      = '0;
      hlt      = 1'b0;
      rval     = '0;
      err      = smeu_pkg::ERR_NONE;
      ds_we    = 1'b0;
      ds_wa    = top_idx;
      ds_wd    = '0;
      rs_we    = 1'b0;
      ga_we    = 1'b0;
      var_we   = 1'b0;
      push     = 1'b0;
      push_val = '0;
      case (smeu_pkg::opcode_type'(op_ff))
         smeu_pkg::OP_PUSH0: push = 1'b1;
         smeu_pkg::OP_POP: st_in = st_pop;
         smeu_pkg::OP_LDCONST: begin
            push     = 1'b1;
            push_val = {{(DW - smeu_pkg::IMM_W){imm_ff[smeu_pkg::IMM_W-1]}}, imm_ff};
         end
         smeu_pkg::OP_LDTABLE: begin
            push     = 1'b1;
            push_val = tconst_ff;
         end
         smeu_pkg::OP_LDARG: begin
            push     = 1'b1;
            push_val = d0_ff;
         end
         smeu_pkg::OP_STARG: begin
            st_in = st_pop;
            ds_we = arg_ok;
            ds_wa = arg_idx;
            ds_wd = d0_ff;
         end
         smeu_pkg::OP_LDVAR: begin
            push     = 1'b1;
            push_val = var_rd;
         end
         smeu_pkg::OP_STVAR: var_we = var_ok;
         smeu_pkg::OP_LDARR: begin
            ds_we = st_pos;
            ds_wd = a_ok ? ga_rd : '0;
         end
         smeu_pkg::OP_STARR: begin
            st_in = st_pop;
            ga_we = a_ok;
         end
         smeu_pkg::OP_INPUT: begin
            err   = smeu_pkg::ERR_INPUT;
            pc_in = pc_ff;
         end
         smeu_pkg::OP_PRINT: begin
            pv    = 1'b1;
            pch   = d0_ff[smeu_pkg::CHAR_W-1:0];
            ds_we = st_pos;
         end
         smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL,
         smeu_pkg::OP_DIV, smeu_pkg::OP_MOD: begin
            st_in = st_pop;
            ds_we = st_ge2;
            ds_wa = sec_idx;
            ds_wd = arith_v;
            if ((smeu_pkg::opcode_type'(op_ff) == smeu_pkg::OP_DIV ||
                 smeu_pkg::opcode_type'(op_ff) == smeu_pkg::OP_MOD) && (d0_ff == '0)) begin
               err = smeu_pkg::ERR_DIV_ZERO;
            end
         end
         smeu_pkg::OP_GOTO: pc_in = target;
         smeu_pkg::OP_GOTO_NZ: begin
            st_in = st_pop;
            if (d0_ff != '0) pc_in = target;
         end
         smeu_pkg::OP_GOTO_EQ: begin
            st_in = st_pop2;
            if (d1_ff == d0_ff) pc_in = target;
         end
         smeu_pkg::OP_GOTO_LT: begin
            st_in = st_pop2;
            if ($signed(d1_ff) < $signed(d0_ff)) pc_in = target;
         end
         smeu_pkg::OP_GOTO_LE: begin
            st_in = st_pop2;
            if (!($signed(d0_ff) < $signed(d1_ff))) pc_in = target;
         end
         smeu_pkg::OP_CALL: begin
            if (call_bad) begin
               err   = smeu_pkg::ERR_OVERFLOW;
               pc_in = pc_ff;
            end else begin
               rs_we = 1'b1;
               rp_in = rp_ff + RPW'(1);
               fb_in = st_ff;
               pc_in = target;
            end
         end
         smeu_pkg::OP_RET: begin
            st_in = nt;
            ds_we = 1'b1;
            ds_wa = nt_idx;
            ds_wd = d0_ff;
            fb_in = ret_fb;
            rp_in = rp_pos ? rp_m1 : '0;
            pc_in = ret_pc + PW'(1);
         end
         smeu_pkg::OP_HALT: begin
            hlt   = 1'b1;
            rval  = d0_ff;
            pc_in = pc_ff;
         end
         default: begin
            err   = smeu_pkg::ERR_ILLEGAL;
            pc_in = pc_ff;
         end
      endcase
      if (push) begin
         if (push_full) begin
            err   = smeu_pkg::ERR_OVERFLOW;
            pc_in = pc_ff;
         end else begin
            ds_we = 1'b1;
            ds_wa = st_ff[DAW-1:0];
            ds_wd = push_val;
            st_in = st_ff + STW'(1);
         end
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff     <= req_opcode;
         imm_ff    <= req_immediate;
         tconst_ff <= req_table_constant;
         need_ff   <= req_callee_frame_need;
      end
      if (cmd.rd1) d0_ff <= (((smeu_pkg::opcode_type'(op_ff) == smeu_pkg::OP_LDARG) ?
                             arg_ok : st_pos) ? ds_rd : '0);
      if (cmd.rd2) d1_ff <= st_ge2 ? ds_rd : '0;
      if (cmd.commit) begin
         rsp_next_pc      <= pc_in;
         rsp_print_valid  <= pv;
         rsp_print_char   <= pch;
         rsp_halted       <= hlt;
         rsp_result_value <= rval;
         rsp_error_code   <= err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff     <= '0;
         st_ff     <= '0;
         fb_ff     <= '0;
         rp_ff     <= '0;
         clr_ff    <= '0;
         rsp_valid <= 1'b0;
         for (int i = 0; i < VARIABLE_COUNT; i++) var_ff[i] <= '0;
      end else begin
         if (cmd.clear) clr_ff <= clr_ff + AAW'(1);
         if (cmd.commit) begin
            pc_ff <= pc_in;
            st_ff <= st_in;
            fb_ff <= fb_in;
            rp_ff <= rp_in;
            if (var_we) var_ff[var_idx] <= d0_ff;
            rsp_valid <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
         end
      end
   end

   always_comb begin
      status            = '0;
      status.clear_last = (clr_ff == CLR_LAST);
      status.is_mul     = (smeu_pkg::opcode_type'(op_ff) == smeu_pkg::OP_MUL);
      status.is_div     = (smeu_pkg::opcode_type'(op_ff) == smeu_pkg::OP_DIV) ||
                          (smeu_pkg::opcode_type'(op_ff) == smeu_pkg::OP_MOD);
      status.div_zero   = (d0_ff == '0);
      status.div_last   = (div_cnt_ff == 6'd63);
      status.rsp_free   = !rsp_valid || rsp_ready;
   end

endmodule
`default_nettype wire

// ===== hdl/stack_machine_execute_unit.sv =====
// Top level of the stack machine execute unit: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none
// Executes one stack-machine instruction per req transaction and returns one rsp transaction
// (next pc, printed char, halt value, error code). After reset the global array is cleared
// one entry a cycle while req_ready stays low. An instruction then passes from acceptance
// through RD0, RD1, RD2 (reads on the single-read-port stack and array memories), EXEC and
// COMMIT; a new transaction is accepted only after the last one has committed. A multiply
// adds MUL1 to MUL3 (three 32x32 partial products on one multiplier) and a divide or modulo
// the DIV state (radix-2 iterative divider, one quotient bit per cycle for 64 bits; a zero
// divisor skips it). A finished result waits in the rsp register while the next transaction
// is accepted; the commit after it stalls until rsp_ready frees that register.
module stack_machine_execute_unit #(
   parameter int DATA_DEPTH     = 1024,
   parameter int RETURN_DEPTH   = 512,
   parameter int VARIABLE_COUNT = 16,
   parameter int ARRAY_DEPTH    = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic        [4:0]  req_opcode,
   input  wire logic signed [15:0] req_immediate,
   input  wire logic signed [63:0] req_table_constant,
   input  wire logic        [10:0] req_callee_frame_need,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic             [15:0] rsp_next_pc,
   output logic                    rsp_print_valid,
   output logic             [7:0]  rsp_print_char,
   output logic                    rsp_halted,
   output logic signed      [63:0] rsp_result_value,
   output logic             [2:0]  rsp_error_code
);

   smeu_pkg::cmd_type    cmd;
   smeu_pkg::status_type status;

   smeu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   smeu_datapath #(
      .DATA_DEPTH     (DATA_DEPTH),
      .RETURN_DEPTH   (RETURN_DEPTH),
      .VARIABLE_COUNT (VARIABLE_COUNT),
      .ARRAY_DEPTH    (ARRAY_DEPTH)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_opcode            (req_opcode),
      .req_immediate         (req_immediate),
      .req_table_constant    (req_table_constant),
      .req_callee_frame_need (req_callee_frame_need),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_next_pc           (rsp_next_pc),
      .rsp_print_valid       (rsp_print_valid),
      .rsp_print_char        (rsp_print_char),
      .rsp_halted            (rsp_halted),
      .rsp_result_value      (rsp_result_value),
      .rsp_error_code        (rsp_error_code)
   );

endmodule
`default_nettype wire
